### rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

    // Screen geometry and tab spacing.
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_WIDTH    = 4;
    localparam int SCREEN_CELLS = COLUMNS * ROWS;

    // Field and internal widths.
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int CELL_W   = 16;
    localparam int POS_W    = 11;
    localparam int ADDR_W   = $clog2(SCREEN_CELLS);
    localparam int CUR_W    = $clog2(SCREEN_CELLS + COLUMNS + TAB_WIDTH + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int PH_W     = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int ADV_W    = $clog2(TAB_WIDTH + 1);
    localparam int SUM_W    = $clog2(COLUMNS + TAB_WIDTH + 1);

    // Tab phase of the column reached by a tab that wraps into the next line,
    // and of the last column of a line.
    localparam logic [PH_W-1:0] TAB_WRAP_PHASE =
        PH_W'((TAB_WIDTH - (COLUMNS % TAB_WIDTH)) % TAB_WIDTH);
    localparam logic [PH_W-1:0] LAST_COL_PHASE = PH_W'((COLUMNS - 1) % TAB_WIDTH);

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

    // Sweep counter operations.
    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_ZERO = 2'd1,
        CNT_BASE = 2'd2,
        CNT_INC  = 2'd3
    } tcw_cnt_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        start;         // item accepted: clear scroll flag
        logic        put_apply;     // apply put character to cursor and memory
        logic        rd_input;      // read the cell addressed by the item
        logic        rd_copy;       // read the source cell of a scroll copy
        logic        zero_wr;       // write zero at the sweep counter
        logic        scroll_apply;  // move cursor up one row, mark scrolled
        logic        home;          // cursor to cell zero
        logic        res_load;      // load the result register
        logic        res_from_read; // result value comes from the read data
        tcw_cnt_op_t cnt_op;
    } tcw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cursor_over;   // cursor is past the last cell
        logic cnt_copy_last; // last scroll copy source is being read
        logic cnt_last;      // sweep counter at the last cell
    } tcw_status_t;

endpackage

### rtl/tcw_if.sv
`timescale 1ns / 1ps
// Handshake channels of the text console writer: item input, result output
// and the color register write port. Depends on tcw_pkg.

// Input item channel.
interface tcw_item_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  cell_index;

    modport source (output valid, kind, char_code, cell_index, input ready);
    modport sink   (input valid, kind, char_code, cell_index, output ready);
endinterface

// Result item channel.
interface tcw_result_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;

    modport source (output valid, cursor_position, cell_value, scrolled, input ready);
    modport sink   (input valid, cursor_position, cell_value, scrolled, output ready);
endinterface

// Color register write channel.
interface tcw_cfg_if import tcw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] text_color;

    modport source (output valid, text_color, input ready);
    modport sink   (input valid, text_color, output ready);
endinterface

### rtl/tcw_datapath.sv
`timescale 1ns / 1ps
// Datapath of the text console writer: screen memory, cursor, sweep counter,
// color register and result register. Depends on tcw_pkg.
module tcw_datapath import tcw_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_cmd_t            cmd,
    output tcw_status_t         status,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [CHAR_W-1:0]   in_char_code,
    input  logic [POS_W-1:0]    in_cell_index,
    input  logic                cfg_valid,
    input  logic [COLOR_W-1:0]  cfg_text_color,
    output logic [POS_W-1:0]    res_cursor_position,
    output logic [CELL_W-1:0]   res_cell_value,
    output logic                res_scrolled
);

    // Screen memory, one write and one registered read per cycle.
    logic [CELL_W-1:0] screen_mem [SCREEN_CELLS];

    logic [CUR_W-1:0]   cursor_reg, cursor_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [PH_W-1:0]    phase_reg, phase_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [COLOR_W-1:0] text_color_reg;
    logic               scrolled_reg;
    logic               copy_pend_reg;
    logic [ADDR_W-1:0]  copy_addr_reg;
    logic [CELL_W-1:0]  rd_data_reg;
    logic               rd_ok_reg;
    logic [POS_W-1:0]   res_cursor_reg;
    logic [CELL_W-1:0]  res_value_reg;
    logic               res_scrolled_reg;

    logic [ADV_W-1:0]   tab_adv;
    logic [SUM_W-1:0]   tab_col_sum;
    logic               put_wr;
    logic [ADDR_W-1:0]  put_addr;
    logic [CELL_W-1:0]  put_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               in_range;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CELL_W-1:0]  wr_data;

    // Cursor, column and tab phase update for a put character.
    always_comb
    begin
        tab_adv     = ADV_W'(TAB_WIDTH) - ADV_W'(phase_reg);
        tab_col_sum = SUM_W'(col_reg) + SUM_W'(tab_adv);
        cursor_next = cursor_reg;
        col_next    = col_reg;
        phase_next  = phase_reg;
        put_wr      = 1'b0;
        put_addr    = cursor_reg[ADDR_W-1:0];
        put_data    = {text_color_reg, in_char_code};
        if (cmd.home)
        begin
            cursor_next = '0;
            col_next    = '0;
            phase_next  = '0;
        end
        else if (cmd.scroll_apply)
        begin
            // The column does not change when the cursor moves up a row.
            cursor_next = cursor_reg - CUR_W'(COLUMNS);
        end
        else if (cmd.put_apply)
        begin
            case (in_char_code)
                CH_NEWLINE:
                begin
                    cursor_next = cursor_reg + CUR_W'(COLUMNS) - CUR_W'(col_reg);
                    col_next    = '0;
                    phase_next  = '0;
                end
                CH_TAB:
                begin
                    cursor_next = cursor_reg + CUR_W'(tab_adv);
                    if (tab_col_sum >= SUM_W'(COLUMNS))
                    begin
                        col_next   = COL_W'(tab_col_sum - SUM_W'(COLUMNS));
                        phase_next = TAB_WRAP_PHASE;
                    end
                    else
                    begin
                        col_next   = COL_W'(tab_col_sum);
                        phase_next = '0;
                    end
                end
                CH_BACKSPACE:
                begin
                    put_wr   = 1'b1;
                    put_data = {text_color_reg, {CHAR_W{1'b0}}};
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - CUR_W'(1);
                        put_addr    = ADDR_W'(cursor_reg - CUR_W'(1));
                        if (col_reg == '0)
                        begin
                            col_next   = COL_W'(COLUMNS - 1);
                            phase_next = LAST_COL_PHASE;
                        end
                        else
                        begin
                            col_next   = col_reg - COL_W'(1);
                            phase_next = (phase_reg == '0) ? PH_W'(TAB_WIDTH - 1)
                                                           : phase_reg - PH_W'(1);
                        end
                    end
                end
                default:
                begin
                    put_wr      = 1'b1;
                    cursor_next = cursor_reg + CUR_W'(1);
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        col_next   = '0;
                        phase_next = '0;
                    end
                    else
                    begin
                        col_next   = col_reg + COL_W'(1);
                        phase_next = (phase_reg == PH_W'(TAB_WIDTH - 1)) ? '0
                                                                         : phase_reg + PH_W'(1);
                    end
                end
            endcase
        end
    end

    // Sweep counter for clearing and scrolling.
    always_comb
    begin
        unique case (cmd.cnt_op)
            CNT_ZERO: cnt_next = '0;
            CNT_BASE: cnt_next = ADDR_W'(SCREEN_CELLS - COLUMNS);
            CNT_INC:  cnt_next = cnt_reg + ADDR_W'(1);
            default:  cnt_next = cnt_reg;
        endcase
    end

    // Read port address: the item's cell or the source row of a scroll copy.
    assign in_range = (in_cell_index < POS_W'(SCREEN_CELLS));
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(cnt_reg + ADDR_W'(COLUMNS));
        if (cmd.rd_copy)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.rd_input && in_range)
        begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(in_cell_index);
        end
    end

    // Write port: a pending scroll copy, a sweep zero or a put character.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        if (copy_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data_reg;
        end
        else if (cmd.zero_wr)
        begin
            wr_en = 1'b1;
        end
        else if (put_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = put_addr;
            wr_data = put_data;
        end
    end

    // Screen memory and read data register.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            screen_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        copy_addr_reg <= cnt_reg;
        if (cmd.rd_input)
        begin
            rd_ok_reg <= (in_kind == KIND_READ) && in_range;
        end
        if (cmd.res_load)
        begin
            res_cursor_reg   <= cmd.home ? '0 : POS_W'(cursor_reg);
            res_value_reg    <= (cmd.res_from_read && rd_ok_reg) ? rd_data_reg : '0;
            res_scrolled_reg <= scrolled_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            col_reg        <= '0;
            phase_reg      <= '0;
            cnt_reg        <= '0;
            text_color_reg <= TEXT_COLOR_RESET;
            scrolled_reg   <= 1'b0;
            copy_pend_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            copy_pend_reg <= cmd.rd_copy;
            if (cfg_valid)
            begin
                text_color_reg <= cfg_text_color;
            end
            if (cmd.start)
            begin
                scrolled_reg <= 1'b0;
            end
            else if (cmd.scroll_apply)
            begin
                scrolled_reg <= 1'b1;
            end
        end
    end

    assign status.cursor_over   = (cursor_reg >= CUR_W'(SCREEN_CELLS));
    assign status.cnt_copy_last = (cnt_reg == ADDR_W'(SCREEN_CELLS - COLUMNS - 1));
    assign status.cnt_last      = (cnt_reg == ADDR_W'(SCREEN_CELLS - 1));

    assign res_cursor_position = res_cursor_reg;
    assign res_cell_value      = res_value_reg;
    assign res_scrolled        = res_scrolled_reg;

    // The column register always tracks a valid column.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS))
        else $error("column register out of range");

    // A new item always finds the cursor on screen.
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> cursor_reg < CUR_W'(SCREEN_CELLS))
        else $error("item accepted with cursor past the screen");

endmodule

### rtl/tcw_controller.sv
`timescale 1ns / 1ps
// Controller of the text console writer: sequences puts, reads, clears,
// scrolls and the memory sweep after reset. Depends on tcw_pkg.
module tcw_controller import tcw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] in_kind,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tcw_status_t       status,
    output tcw_cmd_t          cmd
);

    typedef enum logic [7:0] {
        ST_INIT        = 8'b0000_0001,
        ST_IDLE        = 8'b0000_0010,
        ST_PUT_CHECK   = 8'b0000_0100,
        ST_READ        = 8'b0000_1000,
        ST_CLEAR       = 8'b0001_0000,
        ST_SCROLL_COPY = 8'b0010_0000,
        ST_SCROLL_DRAIN= 8'b0100_0000,
        ST_SCROLL_ZERO = 8'b1000_0000
    } tcw_state_t;

    tcw_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    // The result slot is free, or is emptied at this edge.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.zero_wr = 1'b1;
                cmd.cnt_op  = CNT_INC;
                if (status.cnt_last)
                begin
                    cmd.cnt_op = CNT_ZERO;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.cnt_op = CNT_ZERO;
                if (accept)
                begin
                    cmd.start = 1'b1;
                    if (in_kind == KIND_PUT)
                    begin
                        cmd.put_apply = 1'b1;
                        state_next    = ST_PUT_CHECK;
                    end
                    else if (in_kind == KIND_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.rd_input = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_PUT_CHECK:
            begin
                if (status.cursor_over)
                begin
                    state_next = ST_SCROLL_COPY;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.res_load      = 1'b1;
                cmd.res_from_read = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.zero_wr = 1'b1;
                cmd.cnt_op  = CNT_INC;
                if (status.cnt_last)
                begin
                    cmd.home     = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.cnt_op   = CNT_ZERO;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCROLL_COPY:
            begin
                cmd.rd_copy = 1'b1;
                cmd.cnt_op  = CNT_INC;
                if (status.cnt_copy_last)
                begin
                    cmd.cnt_op = CNT_BASE;
                    state_next = ST_SCROLL_DRAIN;
                end
            end
            ST_SCROLL_DRAIN:
            begin
                // The last copied cell is written in this cycle.
                state_next = ST_SCROLL_ZERO;
            end
            ST_SCROLL_ZERO:
            begin
                cmd.zero_wr = 1'b1;
                cmd.cnt_op  = CNT_INC;
                if (status.cnt_last)
                begin
                    cmd.scroll_apply = 1'b1;
                    cmd.cnt_op       = CNT_ZERO;
                    state_next       = ST_PUT_CHECK;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten");

    // A clear item starts the memory sweep in the next cycle.
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == KIND_CLEAR) |=> state_reg == ST_CLEAR)
        else $error("clear item did not start the sweep");

    // The copy drain cycle is followed by zeroing the bottom row.
    a_drain_then_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCROLL_DRAIN |=> state_reg == ST_SCROLL_ZERO)
        else $error("scroll drain not followed by bottom row clear");

endmodule

### rtl/text_console_writer_unit.sv
`timescale 1ns / 1ps
// Top level of the text console writer: controller and datapath joined by
// command and status structs. Depends on tcw_pkg, tcw_if, tcw_controller, tcw_datapath.
//
//   Channel     Direction  Payload                                   Handshake
//   item_in     in         kind, char_code, cell_index               valid/ready
//   result_out  out        cursor_position, cell_value, scrolled     valid/ready
//   cfg         in         text_color                                valid/ready
//
// A put that scrolls copies every cell below the top row up one row through the screen
// memory, then zeroes the bottom row. A clear item writes zero to every cell, one memory
// write per cell. After reset the block sweeps the memory to zero and accepts no item
// meanwhile; color writes are always taken.
// A result that waits in the output register holds off the next item until it is taken.
module text_console_writer_unit import tcw_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    tcw_item_if.sink      item_in,
    tcw_result_if.source  result_out,
    tcw_cfg_if.sink       cfg
);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    // The color register takes a write in any cycle.
    assign cfg.ready = 1'b1;

    // Sequencing of items.
    tcw_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_kind   (item_in.kind),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Screen memory, cursor and result register.
    tcw_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .in_kind             (item_in.kind),
        .in_char_code        (item_in.char_code),
        .in_cell_index       (item_in.cell_index),
        .cfg_valid           (cfg.valid),
        .cfg_text_color      (cfg.text_color),
        .res_cursor_position (result_out.cursor_position),
        .res_cell_value      (result_out.cell_value),
        .res_scrolled        (result_out.scrolled)
    );

endmodule
